// ----- design/ettok_pkg.sv -----
// Shared types, codes and helpers for the entity text tokenizer.
package ettok_pkg;

    localparam int MAX_RES = 4;
    localparam int CNT_W = 3;
    localparam int LIMIT_W = 13;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_EOD = 2'd2;

    localparam logic [1:0] TYPE_WORD = 2'd0;
    localparam logic [1:0] TYPE_QUOTE = 2'd1;
    localparam logic [1:0] TYPE_BRACE = 2'd2;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [2:0] REG_TOKEN_LIMIT = 3'd0;
    localparam logic [LIMIT_W-1:0] TOKEN_LIMIT_RST = 13'd1024;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_SLASH   = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_QUOTE   = 5'b01000,
        MODE_WORD    = 5'b10000
    } mode_t;

    typedef struct packed {
        logic       trunc;
        logic [1:0] ttype;
        logic [7:0] ch;
        logic [1:0] kind;
    } res_t;

    // All results caused by one input byte.
    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        res_t [MAX_RES-1:0]      res;
    } cmd_t;

    function automatic logic is_brace(input logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
               (b == CH_RPAREN) || (b == CH_APOS);
    endfunction

    function automatic res_t make_res(input logic [1:0] kind, input logic [7:0] ch,
                                      input logic [1:0] ttype, input logic trunc);
        res_t r;
        r.kind = kind;
        r.ch = ch;
        r.ttype = ttype;
        r.trunc = trunc;
        return r;
    endfunction

endpackage

// ----- design/entity_text_tokenizer_core.sv -----
// Top level of the entity text tokenizer: register port, front end, queue and back end.
//
//  Channel  Direction  Signals                          Contents
//  s_*      in         s_tvalid s_tready s_tdata[7:0]   text bytes
//  m_*      out        m_tvalid m_tready m_tdata m_tuser m_tlast  token results
//  APB      in/out     psel penable pwrite paddr pwdata prdata pready  token_limit
//
// A byte is taken every cycle while the four-entry queue has room; its state update is done
// in that same cycle. Each byte causes zero to four results; the output sends one result per
// cycle while m_tready is high, so sustained rate is one byte per cycle when each byte yields
// at most one result, and otherwise the output port sets the pace. Reset clears the scan
// state, queue and output stage, and sets token_limit to 1024. Either side may stall freely.
module entity_text_tokenizer_core #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] token_char
    output logic [4:0]  m_tuser,   // [1:0] item_kind, [3:2] token_type, [4] was_truncated
    output logic        m_tlast,   // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ettok_pkg::LIMIT_W-1:0] limit_reg;
    logic                          accept;
    logic                          push;
    logic                          full;
    logic                          q_pop;
    logic                          q_valid;
    ettok_pkg::cmd_t               push_cmd;
    ettok_pkg::cmd_t               q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == ettok_pkg::REG_TOKEN_LIMIT) ?
                    32'(limit_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ettok_pkg::TOKEN_LIMIT_RST;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr[2] == ettok_pkg::REG_TOKEN_LIMIT[2])
        begin
            limit_reg <= pwdata[ettok_pkg::LIMIT_W-1:0];
        end
    end

    assign s_tready = !full;
    assign accept = s_tvalid && s_tready;

    ettok_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (s_tdata),
        .token_limit (limit_reg),
        .push        (push),
        .cmd         (push_cmd)
    );

    ettok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_cmd),
        .not_empty (q_valid)
    );

    ettok_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- design/ettok_front.sv -----
// Front end: scans each byte, keeps the token state and builds its result list.
module ettok_front #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [7:0]                        text_byte,
    input  logic [ettok_pkg::LIMIT_W-1:0]     token_limit,
    output logic                              push,
    output ettok_pkg::cmd_t                   cmd
);

    localparam int WW = ettok_pkg::LIMIT_W + COUNT_WIDTH;

    ettok_pkg::mode_t           mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0]     kept_reg, kept_next;
    logic                       drop_reg, drop_next;
    logic [ettok_pkg::LIMIT_W-1:0] lim_m1;
    logic [WW-1:0]              lim_wide;
    logic [COUNT_WIDTH-1:0]     cap;
    logic                       do_word;

    // Characters kept per token: limit minus one, floored at zero, capped at the counter range.
    always_comb
    begin
        lim_m1 = (token_limit == '0) ? '0 : token_limit - 1'b1;
        lim_wide = WW'(lim_m1);
        cap = (lim_wide > WW'({COUNT_WIDTH{1'b1}})) ? '1 : lim_wide[COUNT_WIDTH-1:0];
    end

    always_comb
    begin
        mode_next = mode_reg;
        kept_next = kept_reg;
        drop_next = drop_reg;
        cmd = '0;
        do_word = 1'b0;
        case (mode_reg)
            ettok_pkg::MODE_SLASH:
            begin
                kept_next = '0;
                drop_next = 1'b0;
                if (text_byte == ettok_pkg::CH_SLASH)
                begin
                    mode_next = ettok_pkg::MODE_COMMENT;
                end
                else
                begin
                    // A lone slash starts a word; the current byte continues or ends it.
                    if (kept_next < cap)
                    begin
                        cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_CHAR,
                            ettok_pkg::CH_SLASH, ettok_pkg::TYPE_WORD, 1'b0);
                        cmd.cnt = cmd.cnt + 3'd1;
                        kept_next = kept_next + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    do_word = 1'b1;
                end
            end
            ettok_pkg::MODE_COMMENT:
            begin
                if (text_byte == ettok_pkg::CH_NUL)
                begin
                    cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_EOD,
                        8'd0, ettok_pkg::TYPE_WORD, 1'b0);
                    cmd.cnt = cmd.cnt + 3'd1;
                    mode_next = ettok_pkg::MODE_IDLE;
                    kept_next = '0;
                    drop_next = 1'b0;
                end
                else if (text_byte == ettok_pkg::CH_NL)
                begin
                    mode_next = ettok_pkg::MODE_IDLE;
                end
            end
            ettok_pkg::MODE_QUOTE:
            begin
                if (text_byte == ettok_pkg::CH_DQUOTE || text_byte == ettok_pkg::CH_NUL)
                begin
                    cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_END,
                        8'd0, ettok_pkg::TYPE_QUOTE, drop_next);
                    cmd.cnt = cmd.cnt + 3'd1;
                    kept_next = '0;
                    drop_next = 1'b0;
                    mode_next = ettok_pkg::MODE_IDLE;
                    if (text_byte == ettok_pkg::CH_NUL)
                    begin
                        cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_EOD,
                            8'd0, ettok_pkg::TYPE_WORD, 1'b0);
                        cmd.cnt = cmd.cnt + 3'd1;
                    end
                end
                else if (kept_next < cap)
                begin
                    cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_CHAR,
                        text_byte, ettok_pkg::TYPE_QUOTE, 1'b0);
                    cmd.cnt = cmd.cnt + 3'd1;
                    kept_next = kept_next + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
            end
            ettok_pkg::MODE_WORD:
            begin
                do_word = 1'b1;
            end
            default:
            begin
                mode_next = ettok_pkg::MODE_IDLE;
                if (text_byte == ettok_pkg::CH_NUL)
                begin
                    cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_EOD,
                        8'd0, ettok_pkg::TYPE_WORD, 1'b0);
                    cmd.cnt = cmd.cnt + 3'd1;
                    kept_next = '0;
                    drop_next = 1'b0;
                end
                else if (text_byte <= ettok_pkg::CH_SPACE)
                begin
                    mode_next = ettok_pkg::MODE_IDLE;
                end
                else if (text_byte == ettok_pkg::CH_SLASH)
                begin
                    mode_next = ettok_pkg::MODE_SLASH;
                end
                else if (text_byte == ettok_pkg::CH_DQUOTE)
                begin
                    kept_next = '0;
                    drop_next = 1'b0;
                    mode_next = ettok_pkg::MODE_QUOTE;
                end
                else
                begin
                    kept_next = '0;
                    drop_next = 1'b0;
                    if (!ettok_pkg::is_brace(text_byte))
                    begin
                        mode_next = ettok_pkg::MODE_WORD;
                    end
                    if (cap != '0)
                    begin
                        cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_CHAR,
                            text_byte, ettok_pkg::is_brace(text_byte) ?
                            ettok_pkg::TYPE_BRACE : ettok_pkg::TYPE_WORD, 1'b0);
                        cmd.cnt = cmd.cnt + 3'd1;
                        kept_next = kept_next + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (ettok_pkg::is_brace(text_byte))
                    begin
                        cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_END,
                            8'd0, ettok_pkg::TYPE_BRACE, drop_next);
                        cmd.cnt = cmd.cnt + 3'd1;
                        kept_next = '0;
                        drop_next = 1'b0;
                    end
                end
            end
        endcase

        // Handling of a byte that follows the first character of a word.
        if (do_word)
        begin
            if (text_byte <= ettok_pkg::CH_SPACE || ettok_pkg::is_brace(text_byte))
            begin
                cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_END,
                    8'd0, ettok_pkg::TYPE_WORD, drop_next);
                cmd.cnt = cmd.cnt + 3'd1;
                kept_next = '0;
                drop_next = 1'b0;
                mode_next = ettok_pkg::MODE_IDLE;
                if (text_byte == ettok_pkg::CH_NUL)
                begin
                    cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_EOD,
                        8'd0, ettok_pkg::TYPE_WORD, 1'b0);
                    cmd.cnt = cmd.cnt + 3'd1;
                end
                else if (ettok_pkg::is_brace(text_byte))
                begin
                    if (cap != '0)
                    begin
                        cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_CHAR,
                            text_byte, ettok_pkg::TYPE_BRACE, 1'b0);
                        cmd.cnt = cmd.cnt + 3'd1;
                    end
                    cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_END,
                        8'd0, ettok_pkg::TYPE_BRACE, cap == '0);
                    cmd.cnt = cmd.cnt + 3'd1;
                end
            end
            else
            begin
                mode_next = ettok_pkg::MODE_WORD;
                if (kept_next < cap)
                begin
                    cmd.res[cmd.cnt[1:0]] = ettok_pkg::make_res(ettok_pkg::KIND_CHAR,
                        text_byte, ettok_pkg::TYPE_WORD, 1'b0);
                    cmd.cnt = cmd.cnt + 3'd1;
                    kept_next = kept_next + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
            end
        end
    end

    assign push = accept && (cmd.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ettok_pkg::MODE_IDLE;
            kept_reg <= '0;
            drop_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            kept_reg <= kept_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// ----- design/ettok_queue.sv -----
// Small queue of per-byte result lists between the front and back ends.
module ettok_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ettok_pkg::cmd_t  push_data,
    output logic             full,
    input  logic             pop,
    output ettok_pkg::cmd_t  pop_data,
    output logic             not_empty
);

    ettok_pkg::cmd_t              mem [ettok_pkg::QDEPTH];
    logic [ettok_pkg::QAW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [ettok_pkg::QAW:0]      count_reg, count_next;

    assign full = (count_reg == (ettok_pkg::QAW+1)'(ettok_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && not_empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && not_empty)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && not_empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/ettok_back.sv -----
// Back end: plays out the results of each queued byte, one per transaction.
module ettok_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ettok_pkg::cmd_t  q_data,
    input  logic             q_valid,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic [4:0]       m_tuser,
    output logic             m_tlast
);

    ettok_pkg::cmd_t   cur_reg;
    logic [1:0]        idx_reg;
    logic              valid_reg;
    logic              at_last;
    ettok_pkg::res_t   r;

    assign r = cur_reg.res[idx_reg];
    assign at_last = ({1'b0, idx_reg} == cur_reg.cnt - 3'd1);
    // The next list loads when the current one is gone or its last result leaves now.
    assign q_pop = q_valid && (!valid_reg || (m_tready && at_last));

    assign m_tvalid = valid_reg;
    assign m_tdata = r.ch;
    assign m_tuser = {r.trunc, r.ttype, r.kind};
    assign m_tlast = at_last;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (valid_reg && m_tready)
        begin
            if (at_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule
